// File: hdl/adc_ladder_keypad_decoder_macros.svh
// Assertion macros shared by the keypad decoder RTL.
`ifndef ADC_LADDER_KEYPAD_DECODER_MACROS_SVH
`define ADC_LADDER_KEYPAD_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ALKD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ALKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/alkd_pkg.sv
// Package with the word types, widths and register codes of the keypad decoder.
package alkd_pkg;

    localparam int ADC_W      = 10;
    localparam int WINDOW     = 8;   // moving average length, a power of two
    localparam int WIN_SHIFT  = $clog2(WINDOW);
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int SUM_W      = ADC_W + WIN_SHIFT;
    localparam int PERIOD_W   = 16;
    localparam int NUM_KEYS   = 12;
    localparam int LEVELS_W   = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEVELS_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEVELS_HIGH = 3'd4;

    localparam logic [ADC_W-1:0]    RELEASE_RST = 10'd1023;
    localparam logic [ADC_W-1:0]    TOL_RST     = 10'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd200;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             auto_mode;
    } t_in_word;

    typedef struct packed {
        logic [ADC_W-1:0] filtered_level;
        logic             scan_done;
        logic             key_pressed;
        logic [7:0]       floor_toggles;
        logic             up_request;
        logic             down_request;
        logic             work_enable;
        logic             mode_select;
        logic             state_changed;
        logic             restart_auto_timer;
    } t_out_word;

endpackage

// File: hdl/adc_ladder_keypad_decoder.sv
// An accepted word passes through the input register and then the result register before its result word leaves.
// Throughput: one word per cycle unless stalled; the input register refills while the result register is taken.
// The only loop is the state update of the decode stage.
// Reset (synchronous, active low) empties both registers, zeroes the sample window and all
// key state, and loads the configuration registers with their defaults.
// The configuration port is always ready; writes are meant to land while no word is in flight.
`include "adc_ladder_keypad_decoder_macros.svh"

module adc_ladder_keypad_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  alkd_pkg::t_in_word                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output alkd_pkg::t_out_word               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [alkd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [alkd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import alkd_pkg::*;

    // Configuration registers.
    logic [ADC_W-1:0]    r_release_level;
    logic [ADC_W-1:0]    r_tolerance;
    logic [PERIOD_W-1:0] r_scan_period;
    logic [LEVELS_W-1:0] r_key_levels_low;
    logic [LEVELS_W-1:0] r_key_levels_high;

    // Pipeline registers: the input word register and the result word register.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Filter and key state.
    logic [ADC_W-1:0]    r_window [WINDOW];
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_sum;
    logic                r_sample_wait;
    logic [PERIOD_W-1:0] r_scan_wait;
    logic [7:0]          r_floor;
    logic                r_up;
    logic                r_down;
    logic                r_work;
    logic                r_mode;
    logic                r_pressed;

    // Next values computed by the decode stage.
    logic [IDX_W-1:0]    n_idx;
    logic [SUM_W-1:0]    n_sum;
    logic                n_sample_wait;
    logic [PERIOD_W-1:0] n_scan_wait;
    logic [7:0]          n_floor;
    logic                n_up;
    logic                n_down;
    logic                n_work;
    logic                n_mode;
    logic                n_pressed;
    t_out_word           n_out;

    logic                w_advance;
    logic                w_sample_now;
    logic                w_scan_now;
    logic                w_manual;
    logic [ADC_W-1:0]    w_avg;
    logic [ADC_W:0]      w_avg_tol;
    logic                w_release_hit;
    logic [ADC_W-1:0]    w_key [NUM_KEYS];
    logic [NUM_KEYS-1:0] w_hit;
    logic [NUM_KEYS-1:0] w_first;
    logic                w_changed;
    logic                w_restart;

    // The decode stage moves a word forward whenever the result register is free or being emptied.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Every second word stores its sample; the running sum drops the oldest entry.
    assign w_sample_now = r_sample_wait;
    assign w_manual     = !r_in.auto_mode;

    always_comb begin
        n_sample_wait = !r_sample_wait;
        n_sum         = r_sum;
        n_idx         = r_idx;
        if (w_sample_now) begin
            n_sum = r_sum - SUM_W'(r_window[r_idx]) + SUM_W'(r_in.adc_sample);
            if (r_idx == IDX_W'(WINDOW - 1)) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // Division by the window length is a plain bit select of the sum.
    assign w_avg     = n_sum[WIN_SHIFT +: ADC_W];
    assign w_avg_tol = {1'b0, w_avg} + {1'b0, r_tolerance};

    // Windows are compared without wrap: v >= k - tol is tested as v + tol >= k.
    assign w_release_hit = (w_avg_tol >= {1'b0, r_release_level})
                        && ({1'b0, w_avg} <= ({1'b0, r_release_level} + {1'b0, r_tolerance}));

    always_comb begin
        for (int n = 0; n < NUM_KEYS; n++) begin
            if (n < NUM_KEYS / 2) begin
                w_key[n] = r_key_levels_low[n*ADC_W +: ADC_W];
            end else begin
                w_key[n] = r_key_levels_high[(n - NUM_KEYS/2)*ADC_W +: ADC_W];
            end
        end
    end

    always_comb begin
        for (int n = 0; n < NUM_KEYS; n++) begin
            w_hit[n] = ({1'b0, w_avg} <= ({1'b0, w_key[n]} + {1'b0, r_tolerance}))
                    && (w_avg_tol >= {1'b0, w_key[n]});
        end
        // Key one has no lower tolerance.
        w_hit[0] = ({1'b0, w_avg} <= ({1'b0, w_key[0]} + {1'b0, r_tolerance}))
                && (w_avg >= w_key[0]);
    end

    // The lowest matching key wins.
    assign w_first = w_hit & (~w_hit + 1'b1);

    assign w_scan_now = (r_scan_wait >= r_scan_period);

    always_comb begin
        n_scan_wait = r_scan_wait + 1'b1;
        n_floor     = r_floor;
        n_up        = r_up;
        n_down      = r_down;
        n_work      = r_work;
        n_mode      = r_mode;
        n_pressed   = r_pressed;
        w_changed   = 1'b0;
        w_restart   = 1'b0;
        if (w_scan_now) begin
            n_scan_wait = '0;
            if (w_release_hit) begin
                n_pressed = 1'b0;
                if (w_manual) begin
                    n_up   = 1'b0;
                    n_down = 1'b0;
                end
            end else if (w_hit != '0) begin
                n_pressed = 1'b1;
                if (w_manual) begin
                    if (w_first[7:0] != '0) begin
                        n_floor   = r_floor ^ w_first[7:0];
                        w_changed = 1'b1;
                    end else if (w_first[8]) begin
                        if (!r_up) begin
                            n_up      = 1'b1;
                            w_changed = 1'b1;
                            w_restart = 1'b1;
                        end
                    end else if (w_first[9]) begin
                        n_work    = !r_work;
                        w_changed = 1'b1;
                    end else if (w_first[10]) begin
                        if (!r_down) begin
                            n_down    = 1'b1;
                            w_changed = 1'b1;
                            w_restart = 1'b1;
                        end
                    end else begin
                        // Mode key: switching mode off drops both direction latches.
                        n_mode    = !r_mode;
                        w_changed = 1'b1;
                        if (r_mode) begin
                            n_up   = 1'b0;
                            n_down = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        n_out.filtered_level     = w_avg;
        n_out.scan_done          = w_scan_now;
        n_out.key_pressed        = n_pressed;
        n_out.floor_toggles      = n_floor;
        n_out.up_request         = n_up;
        n_out.down_request       = n_down;
        n_out.work_enable        = n_work;
        n_out.mode_select        = n_mode;
        n_out.state_changed      = w_changed;
        n_out.restart_auto_timer = w_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_level   <= RELEASE_RST;
            r_tolerance       <= TOL_RST;
            r_scan_period     <= PERIOD_RST;
            r_key_levels_low  <= '0;
            r_key_levels_high <= '0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_window[i] <= '0;
            end
            r_idx         <= '0;
            r_sum         <= '0;
            r_sample_wait <= 1'b0;
            r_scan_wait   <= '0;
            r_floor       <= '0;
            r_up          <= 1'b0;
            r_down        <= 1'b0;
            r_work        <= 1'b0;
            r_mode        <= 1'b0;
            r_pressed     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RELEASE_LEVEL:   r_release_level   <= i_cfg_data[ADC_W-1:0];
                    CFG_TOLERANCE:       r_tolerance       <= i_cfg_data[ADC_W-1:0];
                    CFG_SCAN_PERIOD:     r_scan_period     <= i_cfg_data[PERIOD_W-1:0];
                    CFG_KEY_LEVELS_LOW:  r_key_levels_low  <= i_cfg_data[LEVELS_W-1:0];
                    CFG_KEY_LEVELS_HIGH: r_key_levels_high <= i_cfg_data[LEVELS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in       <= i_in_data;
            end

            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_out         <= n_out;
                if (w_sample_now) begin
                    r_window[r_idx] <= r_in.adc_sample;
                end
                r_idx         <= n_idx;
                r_sum         <= n_sum;
                r_sample_wait <= n_sample_wait;
                r_scan_wait   <= n_scan_wait;
                r_floor       <= n_floor;
                r_up          <= n_up;
                r_down        <= n_down;
                r_work        <= n_work;
                r_mode        <= n_mode;
                r_pressed     <= n_pressed;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A pending word that cannot move stays in the input register.
    `ALKD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid, "input word lost while stalled")
    // Samples are stored on every second word that passes the decode stage.
    `ALKD_ASSERT_NEXT(a_sample_cadence, i_clk, i_rst_n, w_advance, r_sample_wait != $past(r_sample_wait), "sample cadence broken")
    // While a result word is held, the reported level matches the running sum it came from.
    `ALKD_ASSERT_IMPL(a_level_sum, i_clk, i_rst_n, r_out_valid && !w_advance, r_out.filtered_level == r_sum[WIN_SHIFT +: ADC_W], "filtered level out of step with sum")
    // Pulses only come from a scan, and a timer restart is always a state change.
    `ALKD_ASSERT_IMPL(a_pulse_scan, i_clk, i_rst_n, r_out_valid && r_out.state_changed, r_out.scan_done, "state change without scan")
    `ALKD_ASSERT_IMPL(a_restart_change, i_clk, i_rst_n, r_out_valid && r_out.restart_auto_timer, r_out.state_changed && (r_out.up_request || r_out.down_request), "restart without new latch")

endmodule
